>>> rtl/lpfs_pkg.sv
// Shared types and constants for the length-prefixed frame splitter.
package lpfs_pkg;

  localparam int HEADER_BYTES  = 6;
  localparam int POSITION_BITS = 48;
  localparam int HC_BITS       = 3;

  localparam logic [HC_BITS-1:0] HC_LAST      = HC_BITS'(HEADER_BYTES - 1);
  localparam logic [HC_BITS-1:0] HC_DONE      = HC_BITS'(HEADER_BYTES);
  localparam logic [31:0]        HEADER_LEN   = 32'(HEADER_BYTES);
  localparam logic [31:0]        MAX_FRAME_RST = 32'd67108864;

  // Header byte slots
  localparam logic [HC_BITS-1:0] HC_OPC_LO = 3'd0;
  localparam logic [HC_BITS-1:0] HC_OPC_HI = 3'd1;
  localparam logic [HC_BITS-1:0] HC_LEN_B0 = 3'd2;
  localparam logic [HC_BITS-1:0] HC_LEN_B1 = 3'd3;
  localparam logic [HC_BITS-1:0] HC_LEN_B2 = 3'd4;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic {
    ERR_SHORT = 1'b0,
    ERR_LONG  = 1'b1
  } err_t;

  typedef struct packed {
    kind_t                    kind;
    logic [15:0]              opcode;
    logic [7:0]               payload_byte;
    logic                     frame_last;
    logic [31:0]              frame_length;
    err_t                     error_code;
    logic [POSITION_BITS-1:0] error_position;
  } result_t;

  typedef struct packed {
    logic failed;
    logic in_header;
  } status_t;

endpackage

>>> rtl/lpfs_parse.sv
// Frame parser: header capture, length checks, payload tagging, sticky error.
module lpfs_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             stream_byte,
  input  logic [31:0]            max_frame_size,
  output logic                   res_valid,
  output lpfs_pkg::result_t      res,
  output lpfs_pkg::status_t      status
);

  logic [lpfs_pkg::HC_BITS-1:0]       hc_r, hc_nxt;
  logic [15:0]                        op_r, op_nxt;
  logic [31:0]                        len_r, len_nxt;
  logic [31:0]                        rem_r, rem_nxt;
  logic                               failed_r, failed_nxt;
  lpfs_pkg::err_t                     reason_r, reason_nxt;
  logic [lpfs_pkg::POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [lpfs_pkg::POSITION_BITS-1:0] start_r, start_nxt;
  logic [lpfs_pkg::POSITION_BITS-1:0] pos_inc;
  logic [31:0]                        rem_dec;

  // Saturating position advance and payload countdown
  assign pos_inc = (pos_r != '1) ? pos_r + 1'b1 : pos_r;
  assign rem_dec = (rem_r != '0) ? rem_r - 32'd1 : rem_r;

  // Next state and result for one accepted item
  always_comb begin
    hc_nxt     = hc_r;
    op_nxt     = op_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    failed_nxt = failed_r;
    reason_nxt = reason_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    res_valid  = 1'b0;
    res.kind   = lpfs_pkg::KIND_PAYLOAD;
    res.payload_byte = '0;
    res.frame_last   = 1'b0;

    if (accept) begin
      if (failed_r) begin
        res_valid = 1'b1;
        res.kind  = lpfs_pkg::KIND_ERROR;
      end else if (hc_r < lpfs_pkg::HC_DONE) begin
        if (hc_r == lpfs_pkg::HC_OPC_LO) begin
          start_nxt = pos_r;
        end
        case (hc_r)
          lpfs_pkg::HC_OPC_LO: op_nxt[7:0]    = stream_byte;
          lpfs_pkg::HC_OPC_HI: op_nxt[15:8]   = stream_byte;
          lpfs_pkg::HC_LEN_B0: len_nxt[7:0]   = stream_byte;
          lpfs_pkg::HC_LEN_B1: len_nxt[15:8]  = stream_byte;
          lpfs_pkg::HC_LEN_B2: len_nxt[23:16] = stream_byte;
          default:             len_nxt[31:24] = stream_byte;
        endcase
        hc_nxt  = hc_r + 1'b1;
        pos_nxt = pos_inc;
        // Check the declared length on the final header byte
        if (hc_r == lpfs_pkg::HC_LAST) begin
          if (len_nxt < lpfs_pkg::HEADER_LEN) begin
            failed_nxt = 1'b1;
            reason_nxt = lpfs_pkg::ERR_SHORT;
            res_valid  = 1'b1;
            res.kind   = lpfs_pkg::KIND_ERROR;
          end else if (len_nxt > max_frame_size) begin
            failed_nxt = 1'b1;
            reason_nxt = lpfs_pkg::ERR_LONG;
            res_valid  = 1'b1;
            res.kind   = lpfs_pkg::KIND_ERROR;
          end else if (len_nxt == lpfs_pkg::HEADER_LEN) begin
            hc_nxt         = '0;
            res_valid      = 1'b1;
            res.kind       = lpfs_pkg::KIND_EMPTY;
            res.frame_last = 1'b1;
          end else begin
            rem_nxt = len_nxt - lpfs_pkg::HEADER_LEN;
          end
        end
      end else begin
        // Payload byte: pass it through, mark the last one
        pos_nxt          = pos_inc;
        rem_nxt          = rem_dec;
        res_valid        = 1'b1;
        res.kind         = lpfs_pkg::KIND_PAYLOAD;
        res.payload_byte = stream_byte;
        if (rem_dec == '0) begin
          hc_nxt         = '0;
          res.frame_last = 1'b1;
        end
      end
    end

    res.opcode       = op_nxt;
    res.frame_length = len_nxt;
    if (res.kind == lpfs_pkg::KIND_ERROR) begin
      res.error_code     = reason_nxt;
      res.error_position = start_nxt;
    end else begin
      res.error_code     = lpfs_pkg::ERR_SHORT;
      res.error_position = '0;
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r     <= '0;
      op_r     <= '0;
      len_r    <= '0;
      rem_r    <= '0;
      failed_r <= 1'b0;
      reason_r <= lpfs_pkg::ERR_SHORT;
      pos_r    <= '0;
      start_r  <= '0;
    end else begin
      hc_r     <= hc_nxt;
      op_r     <= op_nxt;
      len_r    <= len_nxt;
      rem_r    <= rem_nxt;
      failed_r <= failed_nxt;
      reason_r <= reason_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
    end
  end

  assign status.failed    = failed_r;
  assign status.in_header = (hc_r < lpfs_pkg::HC_DONE);

endmodule

>>> rtl/lpfs_outbuf.sv
// Two-entry result buffer between the parser and the output channel.
module lpfs_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lpfs_pkg::result_t  push_data,
  output logic               has_space,
  output logic               out_valid,
  input  logic               out_ready,
  output lpfs_pkg::result_t  out_data
);

  lpfs_pkg::result_t head_r, head_nxt;
  lpfs_pkg::result_t tail_r, tail_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              pop;

  assign out_valid = (cnt_r != 2'd0);
  assign has_space = (cnt_r != 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = head_r;

  // Advance the queue on push and pop
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      if (cnt_r == 2'd0) begin
        head_nxt = push_data;
      end else begin
        tail_nxt = push_data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      head_nxt = tail_r;
      cnt_nxt  = cnt_r - 2'd1;
    end else if (pop && push) begin
      if (cnt_r == 2'd1) begin
        head_nxt = push_data;
      end else begin
        head_nxt = tail_r;
        tail_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

>>> rtl/length_prefixed_frame_splitter_unit.sv
// Top level of the length-prefixed frame splitter.
// Takes one stream byte per clock unless the result buffer is full, and gives
// at most one result per byte; each result is registered in the buffer before
// it is presented. The parser holds only counters and a 32-bit length compare
// per byte, and a two-entry result buffer keeps input accepting while a result
// waits on out_ready, so in_ready drops only when both entries are occupied.
// The frame-size limit is written through the cfg_ channel, which is always ready.
module length_prefixed_frame_splitter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_max_frame_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_opcode,
  output logic [7:0]  out_payload_byte,
  output logic        out_frame_last,
  output logic [31:0] out_frame_length,
  output logic        out_error_code,
  output logic [lpfs_pkg::POSITION_BITS-1:0] out_error_position
);

  logic [31:0]        max_frame_r;
  logic               in_accept;
  logic               res_valid;
  lpfs_pkg::result_t  res;
  lpfs_pkg::result_t  out_res;
  lpfs_pkg::status_t  status;

  // Hold the frame-size limit
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= lpfs_pkg::MAX_FRAME_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_frame_r <= cfg_max_frame_size;
    end
  end

  assign in_accept = in_valid && in_ready;

  lpfs_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .stream_byte    (in_stream_byte),
    .max_frame_size (max_frame_r),
    .res_valid      (res_valid),
    .res            (res),
    .status         (status)
  );

  lpfs_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .has_space (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  // Unpack the result item
  assign out_kind           = out_res.kind;
  assign out_opcode         = out_res.opcode;
  assign out_payload_byte   = out_res.payload_byte;
  assign out_frame_last     = out_res.frame_last;
  assign out_frame_length   = out_res.frame_length;
  assign out_error_code     = out_res.error_code;
  assign out_error_position = out_res.error_position;

  // An empty buffer always takes input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result buffer");

  // Once failed, every accepted item yields an error result
  a_sticky_error: assert property (@(posedge clk) disable iff (!rst_n)
    (status.failed && in_accept) |-> (res_valid && res.kind == lpfs_pkg::KIND_ERROR))
    else $error("sticky error not repeated");

  // An error never clears before reset
  a_failed_holds: assert property (@(posedge clk) disable iff (!rst_n)
    status.failed |=> status.failed)
    else $error("failed state cleared");

  // Payload results come only outside the header
  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == lpfs_pkg::KIND_PAYLOAD) |-> !status.in_header)
    else $error("payload result during header");

endmodule

>>> bench/frame_split_checker.sv
// Scoreboard for the frame splitter: predicts each result and checks it.
`timescale 1ns / 1ps
module frame_split_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [31:0]                        cfg_max_frame_size,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [7:0]                         in_stream_byte,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [1:0]                         out_kind,
  input  logic [15:0]                        out_opcode,
  input  logic [7:0]                         out_payload_byte,
  input  logic                               out_frame_last,
  input  logic [31:0]                        out_frame_length,
  input  logic                               out_error_code,
  input  logic [lpfs_pkg::POSITION_BITS-1:0] out_error_position,
  output int                                 mismatches,
  output int                                 pending,
  output int                                 results_seen
);

  // Predicted results not yet seen on the output
  lpfs_pkg::result_t due_results[$];

  // Shadow of the deframer state
  logic [lpfs_pkg::HC_BITS-1:0]       hdr_seen;
  logic [15:0]                        cur_opcode;
  logic [31:0]                        cur_length;
  logic [31:0]                        body_left;
  logic                               broken;
  lpfs_pkg::err_t                     broken_why;
  logic [lpfs_pkg::POSITION_BITS-1:0] byte_pos;
  logic [lpfs_pkg::POSITION_BITS-1:0] frame_base;
  logic [31:0]                        size_limit;

  function automatic lpfs_pkg::result_t shape(input lpfs_pkg::kind_t k,
                                              input logic [7:0] data,
                                              input logic last,
                                              input lpfs_pkg::err_t code,
                                              input logic [lpfs_pkg::POSITION_BITS-1:0] pos);
    lpfs_pkg::result_t r;
    r.kind           = k;
    r.opcode         = cur_opcode;
    r.payload_byte   = data;
    r.frame_last     = last;
    r.frame_length   = cur_length;
    r.error_code     = code;
    r.error_position = pos;
    return r;
  endfunction

  // Append one predicted item at the tail of the queue
  task automatic queue_result(input lpfs_pkg::result_t r);
    due_results = {due_results, r};
  endtask

  // Advance the stream position, holding at all ones
  task automatic bump_position();
    if (byte_pos != '1) begin
      byte_pos = byte_pos + 1'b1;
    end
  endtask

  // Advance the shadow state by one stream byte and queue what it yields
  task automatic predict_byte(input logic [7:0] b);
    if (broken) begin
      queue_result(shape(lpfs_pkg::KIND_ERROR, 8'h00, 1'b0, broken_why, frame_base));
      return;
    end

    if (hdr_seen < lpfs_pkg::HC_DONE) begin
      if (hdr_seen == lpfs_pkg::HC_OPC_LO) begin
        frame_base = byte_pos;
      end
      case (hdr_seen)
        lpfs_pkg::HC_OPC_LO: cur_opcode[7:0]   = b;
        lpfs_pkg::HC_OPC_HI: cur_opcode[15:8]  = b;
        lpfs_pkg::HC_LEN_B0: cur_length[7:0]   = b;
        lpfs_pkg::HC_LEN_B1: cur_length[15:8]  = b;
        lpfs_pkg::HC_LEN_B2: cur_length[23:16] = b;
        default:             cur_length[31:24] = b;
      endcase
      hdr_seen = hdr_seen + 1'b1;
      bump_position();
      if (hdr_seen != lpfs_pkg::HC_DONE) begin
        return;
      end
      // Judge the declared length once the header is complete
      if (cur_length < lpfs_pkg::HEADER_LEN || cur_length > size_limit) begin
        broken     = 1'b1;
        broken_why = (cur_length < lpfs_pkg::HEADER_LEN) ? lpfs_pkg::ERR_SHORT
                                                         : lpfs_pkg::ERR_LONG;
        queue_result(shape(lpfs_pkg::KIND_ERROR, 8'h00, 1'b0, broken_why, frame_base));
      end else if (cur_length == lpfs_pkg::HEADER_LEN) begin
        hdr_seen = '0;
        queue_result(shape(lpfs_pkg::KIND_EMPTY, 8'h00, 1'b1, lpfs_pkg::ERR_SHORT, '0));
      end else begin
        body_left = cur_length - lpfs_pkg::HEADER_LEN;
      end
      return;
    end

    // Payload bytes pass straight through
    bump_position();
    if (body_left != 0) begin
      body_left = body_left - 1'b1;
    end
    if (body_left == 0) begin
      hdr_seen = '0;
      queue_result(shape(lpfs_pkg::KIND_PAYLOAD, b, 1'b1, lpfs_pkg::ERR_SHORT, '0));
    end else begin
      queue_result(shape(lpfs_pkg::KIND_PAYLOAD, b, 1'b0, lpfs_pkg::ERR_SHORT, '0));
    end
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // Watch all three channels on each rising edge
  always @(posedge clk) begin : watch
    lpfs_pkg::result_t want;
    if (!rst_n) begin
      due_results.delete();
      hdr_seen   = '0;
      cur_opcode = '0;
      cur_length = '0;
      body_left  = '0;
      broken     = 1'b0;
      broken_why = lpfs_pkg::ERR_SHORT;
      byte_pos   = '0;
      frame_base = '0;
      size_limit = lpfs_pkg::MAX_FRAME_RST;
    end else begin
      // Check the oldest prediction against the item leaving the block
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("unpredicted result: kind 0x%0h opcode 0x%0h", out_kind, out_opcode);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          compare_field("kind", want.kind, out_kind);
          compare_field("opcode", want.opcode, out_opcode);
          compare_field("payload_byte", want.payload_byte, out_payload_byte);
          compare_field("frame_last", want.frame_last, out_frame_last);
          compare_field("frame_length", want.frame_length, out_frame_length);
          compare_field("error_code", want.error_code, out_error_code);
          compare_field("error_position", want.error_position, out_error_position);
        end
      end
      if (cfg_valid && cfg_ready) begin
        size_limit = cfg_max_frame_size;
      end
      if (in_valid && in_ready) begin
        predict_byte(in_stream_byte);
      end
    end
    pending = due_results.size();
  end

endmodule

>>> bench/length_prefixed_frame_splitter_unit_tb.sv
// Testbench top for the frame splitter: stimulus, idling and the verdict.
`timescale 1ns / 1ps
module length_prefixed_frame_splitter_unit_tb;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [31:0]                        cfg_max_frame_size;
  logic                               in_valid;
  logic                               in_ready;
  logic [7:0]                         in_stream_byte;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [1:0]                         out_kind;
  logic [15:0]                        out_opcode;
  logic [7:0]                         out_payload_byte;
  logic                               out_frame_last;
  logic [31:0]                        out_frame_length;
  logic                               out_error_code;
  logic [lpfs_pkg::POSITION_BITS-1:0] out_error_position;

  int    mismatches;
  int    pending;
  int    results_seen;
  int    bytes_sent;
  int    frames_sent;
  int    limits_used;
  logic  calm = 1'b0;
  string ending_note;

  length_prefixed_frame_splitter_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_frame_size (cfg_max_frame_size),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_stream_byte     (in_stream_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_opcode         (out_opcode),
    .out_payload_byte   (out_payload_byte),
    .out_frame_last     (out_frame_last),
    .out_frame_length   (out_frame_length),
    .out_error_code     (out_error_code),
    .out_error_position (out_error_position)
  );

  frame_split_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_frame_size (cfg_max_frame_size),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_stream_byte     (in_stream_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_opcode         (out_opcode),
    .out_payload_byte   (out_payload_byte),
    .out_frame_last     (out_frame_last),
    .out_frame_length   (out_frame_length),
    .out_error_code     (out_error_code),
    .out_error_position (out_error_position),
    .mismatches         (mismatches),
    .pending            (pending),
    .results_seen       (results_seen)
  );

  always #10 clk = ~clk;

  // Stall the result side at random, except during the calm stretch
  always @(posedge clk) begin
    out_ready <= rst_n && (calm || $urandom_range(0, 99) >= 18);
  end

  // Offer one stream byte, idling first at random, and hold it until taken
  task automatic push_byte(input logic [7:0] b);
    calm <= (bytes_sent >= 700) && (bytes_sent < 1000);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [15:0] opc, input logic [31:0] len);
    push_byte(opc[7:0]);
    push_byte(opc[15:8]);
    for (int k = 0; k < 4; k++) begin
      push_byte(len[8*k +: 8]);
    end
    frames_sent++;
  endtask

  // Mostly short frames, some empty, some at the limit (capped at 206), a few long ones
  function automatic logic [31:0] pick_length(input logic [31:0] cap);
    logic [31:0] roof;
    logic [31:0] near;
    int unsigned roll;
    roof = (cap > 32'd206) ? 32'd206 : cap;
    near = (roof > 32'd38) ? 32'd38 : roof;
    roll = $urandom_range(0, 99);
    if (roll < 15) return lpfs_pkg::HEADER_LEN;
    if (roll < 25) return roof;
    if (roll < 90) return $urandom_range(near, lpfs_pkg::HEADER_LEN);
    return $urandom_range(roof, lpfs_pkg::HEADER_LEN);
  endfunction

  // Send well-formed frames with random content until the byte budget is spent
  task automatic frame_burst(input logic [31:0] cap, input int budget);
    int          stop;
    logic [31:0] len;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      len = pick_length(cap);
      send_header(16'($urandom), len);
      for (int k = 6; k < int'(len); k++) begin
        push_byte(8'($urandom));
      end
    end
  endtask

  // Drain the block, let the header path settle, then write the size limit
  task automatic set_limit(input logic [31:0] value);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_max_frame_size <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limits_used++;
  endtask

  initial begin
    logic [31:0] cap;
    logic [31:0] len;
    int          ending;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_stream_byte     <= 8'h00;
    cfg_valid          <= 1'b0;
    cfg_max_frame_size <= 32'h0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty frames at opcode extremes, one-byte and two-byte bodies
    send_header(16'h0000, lpfs_pkg::HEADER_LEN);
    send_header(16'hFFFF, lpfs_pkg::HEADER_LEN);
    send_header(16'h5AA5, 32'd7);
    push_byte(8'hFF);
    send_header(16'h00FF, 32'd8);
    push_byte(8'h00);
    push_byte(8'h80);

    // Random frames under a series of limits, the extremes among them
    set_limit(lpfs_pkg::HEADER_LEN);
    frame_burst(lpfs_pkg::HEADER_LEN, 150);
    set_limit(32'hFFFF_FFFF);
    frame_burst(32'hFFFF_FFFF, 650);
    cap = $urandom_range(40, 7);
    set_limit(cap);
    frame_burst(cap, 450);
    cap = $urandom_range(300, 41);
    set_limit(cap);
    frame_burst(cap, 450);
    set_limit(lpfs_pkg::MAX_FRAME_RST);
    frame_burst(lpfs_pkg::MAX_FRAME_RST, 200);

    // Close with one bad or unfinished frame; an error stays until reset
    ending = $urandom_range(0, 4);
    case (ending)
      0: begin
        ending_note = "length below header size";
        set_limit($urandom_range(5000, 6));
        len = $urandom_range(5, 0);
      end
      1: begin
        ending_note = "length beyond limit";
        cap = $urandom_range(5000, 6);
        set_limit(cap);
        len = $urandom_range(0, 1) ? cap + 1 : 32'hFFFF_FFFF;
      end
      2: begin
        ending_note = "both bounds broken";
        set_limit($urandom_range(5, 0));
        len = $urandom_range(5, 0);
      end
      3: begin
        ending_note = "limit below header size";
        set_limit($urandom_range(5, 0));
        len = $urandom_range(65535, 6);
      end
      default: begin
        ending_note = "largest frame left open";
        set_limit(32'hFFFF_FFFF);
        len = 32'hFFFF_FFFF;
      end
    endcase
    send_header(16'($urandom), len);
    for (int k = 0; k < 24; k++) begin
      push_byte(8'($urandom));
    end

    // Wait for every predicted result, then idle before the verdict
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes in %0d frames under %0d limit settings, %0d results checked",
             bytes_sent, frames_sent, limits_used, results_seen);
    $display("run closed on: %s", ending_note);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
